// ===== hw/rtl/rotation_matrix_to_quaternion_macros.svh =====
// Assertion macros shared by the rotation-matrix-to-quaternion RTL.
// No dependencies; define ASSERT_OFF to compile the checks away.
`ifndef ROTATION_MATRIX_TO_QUATERNION_MACROS_SVH
`define ROTATION_MATRIX_TO_QUATERNION_MACROS_SVH
`ifndef ASSERT_OFF
`define RMQ_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define RMQ_ASSERT_IMP(label, clk, rst_n, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) else $error(msg);
`else
`define RMQ_ASSERT(label, clk, rst_n, prop, msg)
`define RMQ_ASSERT_IMP(label, clk, rst_n, pre, post, msg)
`endif
`endif

// ===== hw/rtl/rmq_pkg.sv =====
// Types and constants for the rotation-matrix-to-quaternion pipeline.
// No dependencies.
package rmq_pkg;
  localparam int unsigned InW = 18;
  localparam int unsigned TW = 20;
  localparam int unsigned MagW = 19;
  localparam int unsigned SqW = 2 * MagW;
  localparam int unsigned AccW = 60;
  localparam int unsigned NW = 17;
  localparam int unsigned NumLanes = 4;
  localparam int unsigned NumSteps = NW;
  localparam logic signed [TW-1:0] FixOne = TW'(65536);

  typedef logic signed [InW-1:0] fix_t;

  typedef struct packed {
    fix_t m00, m01, m02, m10, m11, m12, m20, m21, m22;
  } mat_t;

  typedef struct packed {
    logic                   vld;
    logic signed [TW-1:0]   t;
    logic [NumLanes-1:0][TW-1:0] v;
  } front_t;

  typedef struct packed {
    logic signed [AccW-1:0] a;
    logic signed [AccW-1:0] p;
    logic signed [AccW-1:0] q;
    logic [NW-1:0]          n;
    logic [NW-1:0]          bit_m;
    logic                   neg;
  } lane_t;

  typedef struct packed {
    logic vld;
    logic pos;
    lane_t [NumLanes-1:0] lane;
  } step_t;
endpackage

// ===== hw/rtl/rmq_in_if.sv =====
// Input channel carrying one rotation matrix per beat.
// Depends on rmq_pkg.
interface rmq_in_if;
  import rmq_pkg::*;
  logic valid;
  logic ready;
  fix_t m00, m01, m02, m10, m11, m12, m20, m21, m22;
  modport source (output valid, m00, m01, m02, m10, m11, m12, m20, m21, m22, input ready);
  modport sink (input valid, m00, m01, m02, m10, m11, m12, m20, m21, m22, output ready);
endinterface

// ===== hw/rtl/rmq_out_if.sv =====
// Output channel carrying one quaternion per beat.
// Depends on rmq_pkg.
interface rmq_out_if;
  import rmq_pkg::*;
  logic valid;
  logic ready;
  fix_t quat_w, quat_x, quat_y, quat_z;
  logic valid_res;
  modport source (output valid, quat_w, quat_x, quat_y, quat_z, valid_res, input ready);
  modport sink (input valid, quat_w, quat_x, quat_y, quat_z, valid_res, output ready);
endinterface

// ===== hw/rtl/rmq_front.sv =====
// Branch selection and operand setup: two register stages that form the
// trace term, the branch values and the initial root-search terms. Uses rmq_pkg.
module rmq_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            vld_i,
  input  rmq_pkg::mat_t   mat_i,
  output rmq_pkg::step_t  step_o
);
  import rmq_pkg::*;

  logic signed [TW-1:0] m00, m01, m02, m10, m11, m12, m20, m21, m22;
  front_t fr_d, fr_q;
  step_t  st_d, st_q;

  assign m00 = TW'(mat_i.m00);
  assign m01 = TW'(mat_i.m01);
  assign m02 = TW'(mat_i.m02);
  assign m10 = TW'(mat_i.m10);
  assign m11 = TW'(mat_i.m11);
  assign m12 = TW'(mat_i.m12);
  assign m20 = TW'(mat_i.m20);
  assign m21 = TW'(mat_i.m21);
  assign m22 = TW'(mat_i.m22);

  always_comb begin
    fr_d.vld = vld_i;
    if (m22 < 0) begin
      if (m00 > m11) begin
        fr_d.t = FixOne + m00 - m11 - m22;
        fr_d.v[0] = m12 - m21;
        fr_d.v[1] = fr_d.t;
        fr_d.v[2] = m01 + m10;
        fr_d.v[3] = m20 + m02;
      end else begin
        fr_d.t = FixOne - m00 + m11 - m22;
        fr_d.v[0] = m20 - m02;
        fr_d.v[1] = m01 + m10;
        fr_d.v[2] = fr_d.t;
        fr_d.v[3] = m12 + m21;
      end
    end else begin
      if (m00 + m11 < 0) begin
        fr_d.t = FixOne - m00 - m11 + m22;
        fr_d.v[0] = m01 - m10;
        fr_d.v[1] = m20 + m02;
        fr_d.v[2] = m12 + m21;
        fr_d.v[3] = fr_d.t;
      end else begin
        fr_d.t = FixOne + m00 + m11 + m22;
        fr_d.v[0] = fr_d.t;
        fr_d.v[1] = m12 - m21;
        fr_d.v[2] = m20 - m02;
        fr_d.v[3] = m01 - m10;
      end
    end
  end

  // The search starts from n = 0, where 2n-1 = -1.
  always_comb begin
    logic signed [TW-1:0]   v;
    logic [MagW-1:0]        mag;
    logic [SqW-1:0]         sq;
    logic signed [AccW-1:0] t_ext;
    st_d.vld = fr_q.vld;
    st_d.pos = fr_q.t > 0;
    t_ext = AccW'(fr_q.t);
    for (int i = 0; i < NumLanes; i++) begin
      v = $signed(fr_q.v[i]);
      mag = v[TW-1] ? MagW'(-v) : MagW'(v);
      sq = SqW'(mag) * SqW'(mag);
      st_d.lane[i].a = (AccW'(sq) <<< 16) - t_ext;
      st_d.lane[i].p = -(t_ext <<< (NW + 1));
      st_d.lane[i].q = t_ext <<< (2 * NW);
      st_d.lane[i].n = '0;
      st_d.lane[i].bit_m = NW'(1) << (NW - 1);
      st_d.lane[i].neg = v[TW-1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fr_q <= '0;
      st_q <= '0;
    end else if (en_i) begin
      fr_q <= fr_d;
      st_q <= st_d;
    end
  end

  assign step_o = st_q;
endmodule

// ===== hw/rtl/rmq_step.sv =====
// One bit of the rounded 128*V/sqrt(T) search for all four lanes, registered.
// Tracks A = 65536*V^2 - k^2*T with shifted copies of k*T and T. Uses rmq_pkg.
module rmq_step (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  rmq_pkg::step_t  step_i,
  output rmq_pkg::step_t  step_o
);
  import rmq_pkg::*;

  step_t st_d, st_q;

  always_comb begin
    logic signed [AccW-1:0] trial;
    logic                   ok;
    lane_t                  ln;
    st_d.vld = step_i.vld;
    st_d.pos = step_i.pos;
    for (int i = 0; i < NumLanes; i++) begin
      ln = step_i.lane[i];
      trial = ln.a - ln.p - ln.q;
      // Once the result has reached 1.0 it stays there.
      ok = !trial[AccW-1] && !ln.n[NW-1];
      if (ok) begin
        ln.a = trial;
        ln.p = ln.p + (ln.q <<< 1);
        ln.n = ln.n | ln.bit_m;
      end
      ln.p = ln.p >>> 1;
      ln.q = ln.q >>> 2;
      ln.bit_m = ln.bit_m >> 1;
      st_d.lane[i] = ln;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= '0;
    end else if (en_i) begin
      st_q <= st_d;
    end
  end

  assign step_o = st_q;
endmodule

// ===== hw/rtl/rotation_matrix_to_quaternion.sv =====
// Channel  Dir  Beat payload
// in_i     in   m00..m22, signed Q1.16 rotation matrix
// out_o    out  quat_w, quat_x, quat_y, quat_z (Q1.16), valid_res
// One matrix per cycle while out_o is not stalled; the pipeline is two setup stages, seventeen
// root-search stages (one result bit each) and the output register.
// The whole pipeline advances together and holds while out_o is stalled.
// Reset clears the setup and search registers and the output valid bit.
// Depends on rmq_pkg, rmq_in_if, rmq_out_if, rmq_front, rmq_step and the macros header.
`include "rotation_matrix_to_quaternion_macros.svh"
module rotation_matrix_to_quaternion (
  input  logic  clk_i,
  input  logic  rst_ni,
  rmq_in_if.sink    in_i,
  rmq_out_if.source out_o
);
  import rmq_pkg::*;

  logic   en;
  mat_t   mat;
  step_t  chain [NumSteps+1];
  logic   out_vld_q;
  fix_t   qw_q, qx_q, qy_q, qz_q;
  logic   res_q;
  fix_t   lane_val [NumLanes];

  assign en = !(out_vld_q && !out_o.ready);
  assign in_i.ready = en;

  assign mat = '{m00: in_i.m00, m01: in_i.m01, m02: in_i.m02,
                 m10: in_i.m10, m11: in_i.m11, m12: in_i.m12,
                 m20: in_i.m20, m21: in_i.m21, m22: in_i.m22};

  rmq_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (in_i.valid),
    .mat_i  (mat),
    .step_o (chain[0])
  );

  for (genvar s = 0; s < NumSteps; s++) begin : g_step
    rmq_step u_step (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .step_i (chain[s]),
      .step_o (chain[s+1])
    );
  end

  always_comb begin
    logic signed [InW-1:0] mag;
    for (int i = 0; i < NumLanes; i++) begin
      mag = {1'b0, chain[NumSteps].lane[i].n};
      if (!chain[NumSteps].pos) begin
        lane_val[i] = '0;
      end else if (chain[NumSteps].lane[i].neg) begin
        lane_val[i] = -mag;
      end else begin
        lane_val[i] = mag;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= chain[NumSteps].vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      qw_q <= lane_val[0];
      qx_q <= lane_val[1];
      qy_q <= lane_val[2];
      qz_q <= lane_val[3];
      res_q <= chain[NumSteps].pos;
    end
  end

  assign out_o.valid = out_vld_q;
  assign out_o.quat_w = qw_q;
  assign out_o.quat_x = qx_q;
  assign out_o.quat_y = qy_q;
  assign out_o.quat_z = qz_q;
  assign out_o.valid_res = res_q;

  `RMQ_ASSERT_IMP(a_fail_zero, clk_i, rst_ni, out_vld_q && !res_q, qw_q == '0 && qx_q == '0 && qy_q == '0 && qz_q == '0, "Failed conversion carries a nonzero quaternion.")
  `RMQ_ASSERT_IMP(a_w_range, clk_i, rst_ni, out_vld_q, qw_q <= 18'sd65536 && qw_q >= -18'sd65536, "quat_w is outside the unit range.")
  `RMQ_ASSERT(a_stall_only, clk_i, rst_ni, in_i.ready || (out_vld_q && !out_o.ready), "Input held off without an output stall.")
endmodule

// ===== tb/sv/rotation_matrix_to_quaternion_tb.sv =====
// Self-checking testbench for rotation_matrix_to_quaternion: directed matrices, then random ones.
// Results are predicted by an exact integer Shepperd conversion and compared beat by beat.
// Depends on rmq_pkg, rmq_in_if, rmq_out_if and the block's RTL.
module rotation_matrix_to_quaternion_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import rmq_pkg::*;

  localparam int unsigned WatchdogLimit = 20000;
  localparam int unsigned DrainCycles = 40;
  localparam int unsigned NumRandom = 1830;

  typedef struct packed {
    fix_t w, x, y, z;
    logic ok;
  } quat_t;

  typedef struct {
    mat_t m;
    logic known;
    quat_t q;
  } row_t;

  logic clk_i;
  logic rst_ni;
  rmq_in_if in_ch ();
  rmq_out_if out_ch ();

  rotation_matrix_to_quaternion u_top (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_ch.sink),
    .out_o (out_ch.source)
  );

  quat_t quat_fifo[$];
  int unsigned err_cnt = 0;
  int unsigned idle_cnt = 0;
  int unsigned in_cnt = 0;
  int unsigned out_cnt = 0;
  int unsigned fail_cnt = 0;
  int unsigned sat_cnt = 0;
  int unsigned src_idle_pct = 0;
  int unsigned snk_idle_pct = 0;
  logic hold_off = 1'b0;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic fix_t rsqrt_scale(longint v, longint t);
    longint mag;
    longint rhs;
    longint lo;
    longint hi;
    longint mid;
    longint k;
    mag = (v < 0) ? -v : v;
    rhs = (mag * mag) << 16;
    lo = 0;
    hi = 65536;
    while (lo < hi) begin
      mid = (lo + hi + 1) / 2;
      k = 2 * mid - 1;
      if (k * k * t <= rhs) lo = mid;
      else hi = mid - 1;
    end
    return (v < 0) ? fix_t'(-lo) : fix_t'(lo);
  endfunction

  function automatic quat_t shepperd(mat_t m);
    longint a00, a01, a02, a10, a11, a12, a20, a21, a22;
    longint t;
    longint v[4];
    quat_t r;
    a00 = m.m00; a01 = m.m01; a02 = m.m02;
    a10 = m.m10; a11 = m.m11; a12 = m.m12;
    a20 = m.m20; a21 = m.m21; a22 = m.m22;
    if (a22 < 0) begin
      if (a00 > a11) begin
        t = 65536 + a00 - a11 - a22;
        v = '{a12 - a21, t, a01 + a10, a20 + a02};
      end else begin
        t = 65536 - a00 + a11 - a22;
        v = '{a20 - a02, a01 + a10, t, a12 + a21};
      end
    end else if (a00 + a11 < 0) begin
      t = 65536 - a00 - a11 + a22;
      v = '{a01 - a10, a20 + a02, a12 + a21, t};
    end else begin
      t = 65536 + a00 + a11 + a22;
      v = '{t, a12 - a21, a20 - a02, a01 - a10};
    end
    r = '0;
    if (t > 0) begin
      r.w = rsqrt_scale(v[0], t);
      r.x = rsqrt_scale(v[1], t);
      r.y = rsqrt_scale(v[2], t);
      r.z = rsqrt_scale(v[3], t);
      r.ok = 1'b1;
    end
    return r;
  endfunction

  function automatic fix_t rand_entry();
    int unsigned sel;
    sel = $urandom_range(0, 9);
    if (sel == 0) return fix_t'($urandom);
    if (sel == 1) return ($urandom_range(0, 1) != 0) ? fix_t'(65536) : fix_t'(-65536);
    return fix_t'(int'($urandom_range(0, 131072)) - 65536);
  endfunction

  // Builds a near-rotation from a random unit quaternion so all branches are hit with
  // well-formed data; the remainder are raw entries.
  function automatic mat_t rand_matrix();
    mat_t m;
    real a, b, c, d, n;
    if ($urandom_range(0, 3) == 0) begin
      m = {rand_entry(), rand_entry(), rand_entry(), rand_entry(), rand_entry(),
           rand_entry(), rand_entry(), rand_entry(), rand_entry()};
      return m;
    end
    a = $urandom_range(0, 2000) - 1000.0;
    b = $urandom_range(0, 2000) - 1000.0;
    c = $urandom_range(0, 2000) - 1000.0;
    d = $urandom_range(0, 2000) - 1000.0;
    n = a * a + b * b + c * c + d * d;
    if (n < 1.0) n = 1.0;
    m.m00 = fix_t'($rtoi(65536.0 * (a*a + b*b - c*c - d*d) / n));
    m.m01 = fix_t'($rtoi(65536.0 * 2.0 * (b*c - a*d) / n));
    m.m02 = fix_t'($rtoi(65536.0 * 2.0 * (b*d + a*c) / n));
    m.m10 = fix_t'($rtoi(65536.0 * 2.0 * (b*c + a*d) / n));
    m.m11 = fix_t'($rtoi(65536.0 * (a*a - b*b + c*c - d*d) / n));
    m.m12 = fix_t'($rtoi(65536.0 * 2.0 * (c*d - a*b) / n));
    m.m20 = fix_t'($rtoi(65536.0 * 2.0 * (b*d - a*c) / n));
    m.m21 = fix_t'($rtoi(65536.0 * 2.0 * (c*d + a*b) / n));
    m.m22 = fix_t'($rtoi(65536.0 * (a*a - b*b - c*c + d*d) / n));
    return m;
  endfunction

  task automatic send_matrix(mat_t m);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    {in_ch.m00, in_ch.m01, in_ch.m02, in_ch.m10, in_ch.m11, in_ch.m12,
     in_ch.m20, in_ch.m21, in_ch.m22} <= m;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && in_ch.valid && in_ch.ready) begin
      quat_fifo.push_back(shepperd({in_ch.m00, in_ch.m01, in_ch.m02, in_ch.m10,
                                    in_ch.m11, in_ch.m12, in_ch.m20, in_ch.m21,
                                    in_ch.m22}));
      in_cnt++;
    end
  end

  always @(posedge clk_i) begin
    quat_t exp_q;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      out_cnt++;
      if (quat_fifo.size() == 0) begin
        $error("unexpected beat on out_o");
        err_cnt++;
      end else begin
        exp_q = quat_fifo.pop_front();
        if (!exp_q.ok) fail_cnt++;
        if (exp_q.w == 18'sd65536 || exp_q.w == -18'sd65536) sat_cnt++;
        if (out_ch.valid_res !== exp_q.ok) begin
          $error("valid_res: expected %0d, got %0d", exp_q.ok, out_ch.valid_res);
          err_cnt++;
        end
        if (out_ch.quat_w !== exp_q.w) begin
          $error("quat_w: expected %0d, got %0d", exp_q.w, out_ch.quat_w);
          err_cnt++;
        end
        if (out_ch.quat_x !== exp_q.x) begin
          $error("quat_x: expected %0d, got %0d", exp_q.x, out_ch.quat_x);
          err_cnt++;
        end
        if (out_ch.quat_y !== exp_q.y) begin
          $error("quat_y: expected %0d, got %0d", exp_q.y, out_ch.quat_y);
          err_cnt++;
        end
        if (out_ch.quat_z !== exp_q.z) begin
          $error("quat_z: expected %0d, got %0d", exp_q.z, out_ch.quat_z);
          err_cnt++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= !hold_off && ($urandom_range(0, 99) >= snk_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || !rst_ni) begin
      idle_cnt <= 0;
    end else begin
      idle_cnt <= idle_cnt + 1;
      if (idle_cnt >= WatchdogLimit) begin
        $display("rotation_matrix_to_quaternion_tb: done, errors");
        $finish;
      end
    end
  end

  initial begin
    hold_off = 1'b1;
    repeat (300) @(posedge clk_i);
    hold_off = 1'b0;
  end

  initial begin
    row_t dir_rows[$];
    row_t r;
    mat_t m;
    in_ch.valid = 1'b0;
    {in_ch.m00, in_ch.m01, in_ch.m02, in_ch.m10, in_ch.m11, in_ch.m12,
     in_ch.m20, in_ch.m21, in_ch.m22} = '0;
    rst_ni = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    r.known = 1'b1;
    r.m = {18'sd65536, 18'sd0, 18'sd0, 18'sd0, 18'sd65536, 18'sd0, 18'sd0, 18'sd0, 18'sd65536};
    r.q = {18'sd65536, 18'sd0, 18'sd0, 18'sd0, 1'b1};
    dir_rows.push_back(r);
    r.m = {18'sd65536, 18'sd0, 18'sd0, 18'sd0, -18'sd65536, 18'sd0, 18'sd0, 18'sd0, -18'sd65536};
    r.q = {18'sd0, 18'sd65536, 18'sd0, 18'sd0, 1'b1};
    dir_rows.push_back(r);
    r.m = {-18'sd65536, 18'sd0, 18'sd0, 18'sd0, 18'sd65536, 18'sd0, 18'sd0, 18'sd0, -18'sd65536};
    r.q = {18'sd0, 18'sd0, 18'sd65536, 18'sd0, 1'b1};
    dir_rows.push_back(r);
    r.m = {-18'sd65536, 18'sd0, 18'sd0, 18'sd0, -18'sd65536, 18'sd0, 18'sd0, 18'sd0, 18'sd65536};
    r.q = {18'sd0, 18'sd0, 18'sd0, 18'sd65536, 1'b1};
    dir_rows.push_back(r);
    // Extreme diagonal entries in each branch.
    r.m = {18'sd0, 18'sd0, 18'sd0, 18'sd0, 18'sd0, 18'sd0, 18'sd0, 18'sd0, -18'sd131072};
    r.known = 1'b0;
    dir_rows.push_back(r);
    r.m = {18'sd131071, 18'sd0, 18'sd0, 18'sd0, 18'sd0, 18'sd0, 18'sd0, 18'sd0, 18'sd0};
    dir_rows.push_back(r);
    r.m = {-18'sd131072, 18'sd0, 18'sd0, 18'sd0, -18'sd131072, 18'sd0, 18'sd0, 18'sd0,
           18'sd0};
    r.known = 1'b0;
    dir_rows.push_back(r);
    r.m = {-18'sd65536, 18'sd0, 18'sd0, 18'sd0, 18'sd131071, 18'sd0, 18'sd0, 18'sd0,
           -18'sd131072};
    dir_rows.push_back(r);
    r.m = {18'sd131071, 18'sd131071, -18'sd131072, 18'sd131071, -18'sd131072, 18'sd131071,
           -18'sd131072, 18'sd131071, -18'sd131072};
    dir_rows.push_back(r);
    r.m = {18'sd131071, -18'sd131072, 18'sd131071, -18'sd131072, 18'sd131071, -18'sd131072,
           18'sd131071, -18'sd131072, 18'sd131071};
    dir_rows.push_back(r);
    r.m = {18'sd0, -18'sd65536, 18'sd0, 18'sd65536, 18'sd0, 18'sd0, 18'sd0, 18'sd0,
           18'sd65536};
    dir_rows.push_back(r);
    r.m = {18'sd0, 18'sd1, -18'sd1, 18'sd1, -18'sd1, 18'sd0, -18'sd1, 18'sd1, -18'sd1};
    dir_rows.push_back(r);
    r.m = {18'sd10, 18'sd0, 18'sd0, 18'sd0, 18'sd10, 18'sd0, 18'sd0, 18'sd0, -18'sd65536};
    dir_rows.push_back(r);
    r.m = {-18'sd32768, 18'sd0, 18'sd0, 18'sd0, 18'sd32767, 18'sd0, 18'sd0, 18'sd0, 18'sd0};
    dir_rows.push_back(r);

    src_idle_pct = 20;
    snk_idle_pct = 47;
    foreach (dir_rows[i]) begin
      if (dir_rows[i].known && shepperd(dir_rows[i].m) !== dir_rows[i].q) begin
        $error("directed row %0d: table and prediction disagree", i);
        err_cnt++;
      end
      send_matrix(dir_rows[i].m);
    end
    for (int i = 0; i < NumRandom; i++) begin
      if (i == NumRandom / 3) begin
        src_idle_pct = 47;
        snk_idle_pct = 20;
      end else if (i == 2 * NumRandom / 3) begin
        src_idle_pct = 0;
        snk_idle_pct = 0;
      end
      m = rand_matrix();
      send_matrix(m);
    end
    in_ch.valid <= 1'b0;

    while (quat_fifo.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    $display("Sent %0d matrices, checked %0d quaternions (%0d with no positive trace term,",
             in_cnt, out_cnt, fail_cnt);
    $display("  %0d with w saturated) over three idling patterns and a long output stall.",
             sat_cnt);
    if (err_cnt == 0) begin
      $display("rotation_matrix_to_quaternion_tb: done, clean");
    end else begin
      $display("rotation_matrix_to_quaternion_tb: done, errors");
    end
    $finish;
  end
endmodule
